/* design/cstp_pkg.sv */
// types and constants for the call-site table parser
package cstp_pkg;

	// parser phase
	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_TLEN     = 3'd1,
		PH_RECORDS  = 3'd2,
		PH_DONE_OK  = 3'd3,
		PH_DONE_ERR = 3'd4
	} phase_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_ENC  = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_TRUNC    = 3'd3,
		ST_ACTION   = 3'd4
	} status_t;

	// header layout
	localparam logic [3:0] HDR_SKIP_BYTES = 4'd8;
	localparam logic [3:0] HDR_LAST_ENC   = 4'd10;
	localparam logic [3:0] HDR_BYTES      = 4'd11;
	localparam logic [7:0] ENC_OMIT       = 8'hff;
	localparam logic [7:0] ENC_ULEB128    = 8'h01;

	// uleb128 decoding
	localparam logic [6:0] ULEB_STEP      = 7'd7;
	localparam logic [6:0] ULEB_TOP_SHIFT = 7'd63;
	localparam logic [6:0] ULEB_MAX_SHIFT = 7'd64;

	// record field order
	localparam logic [1:0] FLD_START  = 2'd0;
	localparam logic [1:0] FLD_LENGTH = 2'd1;
	localparam logic [1:0] FLD_PAD    = 2'd2;
	localparam logic [1:0] FLD_ACTION = 2'd3;

endpackage

/* design/call_site_table_parser_top.sv */
// call-site table parser: byte stream in, landing pad records and status out
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------------------
//  in      | in_valid/in_ready  | data_byte[7:0], last_byte
//  out     | out_valid/out_ready| range_end[63:0], pad_offset[63:0], record_valid,
//          |                    | status[2:0], table_end
//
//  one item a cycle while no result is held (out_valid low or out_ready high): a byte
//  waits in the input register, then the parser update and the result register load happen on the same edge.
//  the throughput is set by the parser state loop (uleb shift/or and the table length
//  decrement), a register-to-register feedback loop; the start plus length add feeds only
//  the result register.
//  arst_n clears the parser state and both valid flags; payload registers are not reset.
//  a held result stalls the parser and the input register; new bytes keep flowing while out_ready.
module call_site_table_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] range_end,
	output logic [63:0] pad_offset,
	output logic        record_valid,
	output logic [2:0]  status,
	output logic        table_end
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// parser state
	cstp_pkg::phase_t phase_q, phase_n;
	logic [3:0]  hdr_cnt_q, hdr_cnt_n;
	logic [63:0] uleb_val_q, uleb_val_n;
	logic [6:0]  uleb_shift_q, uleb_shift_n;
	logic [1:0]  fld_idx_q, fld_idx_n;
	logic [63:0] tbl_left_q, tbl_left_n;
	logic [63:0] site_start_q, site_start_n;
	logic [63:0] site_len_q, site_len_n;
	logic [63:0] pad_q, pad_n;

	// result register
	logic        out_valid_q;
	logic [63:0] range_end_q, pad_offset_q;
	logic        rec_valid_q, table_end_q;
	cstp_pkg::status_t status_q;

	// stage handshake
	logic advance;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// uleb128 byte feed
	logic [63:0] slice_sh;
	logic        feed_ovf, feed_done;
	logic [63:0] feed_val;
	assign slice_sh  = {57'd0, byte_s1[6:0]} << uleb_shift_q;
	assign feed_ovf  = (uleb_shift_q >= cstp_pkg::ULEB_MAX_SHIFT) ||
	                   ((uleb_shift_q == cstp_pkg::ULEB_TOP_SHIFT) && (byte_s1[6:1] != 6'd0));
	assign feed_done = !feed_ovf && !byte_s1[7];
	// bits above the current shift are still zero, so or equals add
	assign feed_val  = uleb_val_q | slice_sh;

	// parser next state and result
	logic [63:0] tbl_dec;
	logic        rec_done, emit, put_done, want_ok;
	logic [7:0]  enc_want;
	cstp_pkg::status_t err;
	assign tbl_dec = tbl_left_q - 64'd1;

	always_comb begin
		phase_n      = phase_q;
		hdr_cnt_n    = hdr_cnt_q;
		uleb_val_n   = uleb_val_q;
		uleb_shift_n = uleb_shift_q;
		fld_idx_n    = fld_idx_q;
		tbl_left_n   = tbl_left_q;
		site_start_n = site_start_q;
		site_len_n   = site_len_q;
		pad_n        = pad_q;
		err          = cstp_pkg::ST_OK;
		rec_done     = 1'b0;
		emit         = 1'b0;
		put_done     = 1'b0;
		want_ok      = 1'b1;
		enc_want     = (hdr_cnt_q == cstp_pkg::HDR_LAST_ENC) ? cstp_pkg::ENC_ULEB128
		                                                     : cstp_pkg::ENC_OMIT;
		case (phase_q)
			cstp_pkg::PH_HEADER: begin
				if (hdr_cnt_q >= cstp_pkg::HDR_SKIP_BYTES && byte_s1 != enc_want) begin
					err = cstp_pkg::ST_BAD_ENC;
				end
				hdr_cnt_n = hdr_cnt_q + 4'd1;
				if (hdr_cnt_n >= cstp_pkg::HDR_BYTES) begin
					phase_n = cstp_pkg::PH_TLEN;
				end
				if (err == cstp_pkg::ST_OK && last_s1) begin
					err = cstp_pkg::ST_TRUNC;
				end
			end
			cstp_pkg::PH_TLEN: begin
				if (feed_ovf) begin
					err = cstp_pkg::ST_OVERFLOW;
				end else begin
					uleb_val_n   = feed_val;
					uleb_shift_n = uleb_shift_q + cstp_pkg::ULEB_STEP;
					if (feed_done) begin
						tbl_left_n   = feed_val;
						phase_n      = (feed_val != 64'd0) ? cstp_pkg::PH_RECORDS
						                                   : cstp_pkg::PH_DONE_OK;
						uleb_val_n   = 64'd0;
						uleb_shift_n = 7'd0;
					end
				end
				if (err == cstp_pkg::ST_OK && last_s1) begin
					if (phase_n == cstp_pkg::PH_DONE_OK) begin
						put_done = 1'b1;
					end else begin
						err = cstp_pkg::ST_TRUNC;
					end
				end
			end
			cstp_pkg::PH_RECORDS: begin
				tbl_left_n = tbl_dec;
				if (feed_ovf) begin
					err = cstp_pkg::ST_OVERFLOW;
				end else begin
					uleb_val_n   = feed_val;
					uleb_shift_n = uleb_shift_q + cstp_pkg::ULEB_STEP;
					if (feed_done) begin
						case (fld_idx_q)
							cstp_pkg::FLD_START:  site_start_n = feed_val;
							cstp_pkg::FLD_LENGTH: site_len_n   = feed_val;
							cstp_pkg::FLD_PAD:    pad_n        = feed_val;
							default: begin
								rec_done = 1'b1;
								if (feed_val != 64'd0) begin
									err = cstp_pkg::ST_ACTION;
								end else if (pad_q != 64'd0) begin
									emit = 1'b1;
								end
							end
						endcase
						fld_idx_n    = fld_idx_q + 2'd1;
						uleb_val_n   = 64'd0;
						uleb_shift_n = 7'd0;
					end
				end
				// table length and end of data checks
				if (err == cstp_pkg::ST_OK) begin
					if (tbl_dec == 64'd0) begin
						if (!rec_done) begin
							err     = cstp_pkg::ST_TRUNC;
							want_ok = 1'b0;
						end else begin
							phase_n = cstp_pkg::PH_DONE_OK;
						end
					end
					if (want_ok && last_s1 && phase_n == cstp_pkg::PH_RECORDS) begin
						err = cstp_pkg::ST_TRUNC;
					end
					if (err == cstp_pkg::ST_OK && !emit && last_s1) begin
						put_done = 1'b1;
					end
				end
			end
			cstp_pkg::PH_DONE_OK: begin
				if (last_s1) begin
					put_done = 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (err != cstp_pkg::ST_OK) begin
			phase_n = cstp_pkg::PH_DONE_ERR;
		end
		// final byte returns the parser to its reset state
		if (last_s1) begin
			phase_n      = cstp_pkg::PH_HEADER;
			hdr_cnt_n    = 4'd0;
			uleb_val_n   = 64'd0;
			uleb_shift_n = 7'd0;
			fld_idx_n    = 2'd0;
			tbl_left_n   = 64'd0;
			site_start_n = 64'd0;
			site_len_n   = 64'd0;
			pad_n        = 64'd0;
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cstp_pkg::PH_HEADER;
			hdr_cnt_q    <= 4'd0;
			uleb_val_q   <= 64'd0;
			uleb_shift_q <= 7'd0;
			fld_idx_q    <= 2'd0;
			tbl_left_q   <= 64'd0;
			site_start_q <= 64'd0;
			site_len_q   <= 64'd0;
			pad_q        <= 64'd0;
		end else if (advance) begin
			phase_q      <= phase_n;
			hdr_cnt_q    <= hdr_cnt_n;
			uleb_val_q   <= uleb_val_n;
			uleb_shift_q <= uleb_shift_n;
			fld_idx_q    <= fld_idx_n;
			tbl_left_q   <= tbl_left_n;
			site_start_q <= site_start_n;
			site_len_q   <= site_len_n;
			pad_q        <= pad_n;
		end
	end

	// result valid flag
	logic has_result;
	assign has_result = (err != cstp_pkg::ST_OK) || emit || put_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= has_result;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			if (err != cstp_pkg::ST_OK) begin
				range_end_q  <= 64'd0;
				pad_offset_q <= 64'd0;
				rec_valid_q  <= 1'b0;
				status_q     <= err;
				table_end_q  <= 1'b1;
			end else if (emit) begin
				range_end_q  <= site_start_q + site_len_q;
				pad_offset_q <= pad_q;
				rec_valid_q  <= 1'b1;
				status_q     <= cstp_pkg::ST_OK;
				table_end_q  <= last_s1;
			end else begin
				range_end_q  <= 64'd0;
				pad_offset_q <= 64'd0;
				rec_valid_q  <= 1'b0;
				status_q     <= cstp_pkg::ST_OK;
				table_end_q  <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign range_end    = range_end_q;
	assign pad_offset   = pad_offset_q;
	assign record_valid = rec_valid_q;
	assign status       = status_q;
	assign table_end    = table_end_q;

`ifndef SYNTH
	// a record result always carries ok status and a nonzero pad
	a_rec_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rec_valid_q |-> status_q == cstp_pkg::ST_OK && pad_offset_q != 64'd0)
		else $error("record result with bad status or zero pad");

	// an error result ends the table
	a_err_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != cstp_pkg::ST_OK |-> table_end_q && !rec_valid_q)
		else $error("error result does not end the table");

	// the final byte puts the parser back to the header phase
	a_last_reset: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> phase_q == cstp_pkg::PH_HEADER && hdr_cnt_q == 4'd0 &&
		uleb_shift_q == 7'd0 && fld_idx_q == 2'd0)
		else $error("parser state not cleared after final byte");

	// the final byte yields a table end result unless an error already ended the table
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 && phase_q != cstp_pkg::PH_DONE_ERR |=> out_valid_q && table_end_q)
		else $error("final byte gave no table end result");
`endif

endmodule
